// ===== sv/mi_pkg.sv =====
// Shared constants and types for the modular inverse core.
package mi_pkg;

  // Default operand width.
  localparam int MI_WIDTH_DEF = 32;

  // Index of the modulus register in the configuration space.
  localparam int MI_REG_MODULUS = 0;

  // Compare results from the shift-subtract unit to the sequencer.
  typedef struct packed {
    logic fits;      // divisor <= running remainder
    logic dbl_fits;  // twice the divisor <= running remainder
  } mi_alu_stat_t;

endpackage

// ===== sv/mi_in_if.sv =====
// Input channel carrying one value to invert per beat.
interface mi_in_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== sv/mi_out_if.sv =====
// Result channel carrying one inverse and its exists flag per beat.
interface mi_out_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             exists;

  modport source (output valid, output inverse, output exists, input ready);
  modport sink (input valid, input inverse, input exists, output ready);
endinterface

// ===== sv/mi_alu.sv =====
// Shared shift-subtract unit: remainder subtract, coefficient add and compares.
module mi_alu import mi_pkg::*; #(
  parameter int WIDTH = MI_WIDTH_DEF
) (
  input  logic [WIDTH-1:0] rem,
  input  logic [WIDTH-1:0] acc,
  input  logic [WIDTH-1:0] dr,
  input  logic [WIDTH-1:0] du,
  output mi_alu_stat_t     stat,
  output logic [WIDTH-1:0] rem_diff,
  output logic [WIDTH-1:0] acc_sum
);

  // Trial subtraction of the aligned divisor and matching coefficient update.
  assign rem_diff = rem - dr;
  assign acc_sum  = acc + du;

  // Compares that steer alignment and the subtract decision.
  assign stat.fits     = (dr <= rem);
  assign stat.dbl_fits = ({dr, 1'b0} <= {1'b0, rem});

endmodule

// ===== sv/mi_engine.sv =====
// Sequencer and datapath registers running the extended Euclidean algorithm.
module mi_engine import mi_pkg::*; #(
  parameter int WIDTH = MI_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mi_in_if.sink            in_ch,
  mi_out_if.source         out_ch,
  input  logic [WIDTH-1:0] modulus
);

  localparam int KW = $clog2(WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ALIGN = 4'b0010,
    ST_SUB   = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;   // running r0
  logic [WIDTH-1:0] acc_r, acc_nxt;   // running u0 magnitude
  logic [WIDTH-1:0] r1_r, r1_nxt;     // divisor of the current step
  logic [WIDTH-1:0] u1_r, u1_nxt;     // coefficient tied to the divisor
  logic [WIDTH-1:0] dr_r, dr_nxt;     // divisor shifted left by k
  logic [WIDTH-1:0] du_r, du_nxt;     // coefficient shifted left by k
  logic [KW-1:0]    k_r, k_nxt;
  logic             neg0_r, neg0_nxt;
  logic             neg1_r, neg1_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_inverse_r, out_inverse_nxt;
  logic             out_exists_r, out_exists_nxt;

  mi_alu_stat_t     alu_stat;
  logic [WIDTH-1:0] rem_diff;
  logic [WIDTH-1:0] acc_sum;
  logic [WIDTH-1:0] rem_step;
  logic [WIDTH-1:0] acc_step;
  logic             in_fire;
  logic             out_free;
  logic             gcd_one;
  logic [WIDTH-1:0] inv_sel;

  mi_alu #(
    .WIDTH(WIDTH)
  ) u_alu (
    .rem      (rem_r),
    .acc      (acc_r),
    .dr       (dr_r),
    .du       (du_r),
    .stat     (alu_stat),
    .rem_diff (rem_diff),
    .acc_sum  (acc_sum)
  );

  // Handshakes: one item at a time, result register frees the input side.
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid_r || out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.inverse = out_inverse_r;
  assign out_ch.exists  = out_exists_r;

  // Remainder and coefficient after this cycle's trial subtraction.
  assign rem_step = alu_stat.fits ? rem_diff : rem_r;
  assign acc_step = alu_stat.fits ? acc_sum : acc_r;

  // Final mapping of the signed coefficient into 0 to modulus-1.
  assign gcd_one = (rem_r == WIDTH'(1));
  always_comb begin
    if ((acc_r == '0) || (acc_r == modulus)) begin
      inv_sel = '0;
    end else if (neg0_r) begin
      inv_sel = modulus - acc_r;
    end else begin
      inv_sel = acc_r;
    end
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt       = state_r;
    rem_nxt         = rem_r;
    acc_nxt         = acc_r;
    r1_nxt          = r1_r;
    u1_nxt          = u1_r;
    dr_nxt          = dr_r;
    du_nxt          = du_r;
    k_nxt           = k_r;
    neg0_nxt        = neg0_r;
    neg1_nxt        = neg1_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_inverse_nxt = out_inverse_r;
    out_exists_nxt  = out_exists_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // A value not below the modulus leaves r0 at zero, which fails the gcd test.
          rem_nxt  = (in_ch.value < modulus) ? modulus : '0;
          acc_nxt  = '0;
          r1_nxt   = in_ch.value;
          u1_nxt   = WIDTH'(1);
          dr_nxt   = in_ch.value;
          du_nxt   = WIDTH'(1);
          k_nxt    = '0;
          neg0_nxt = 1'b0;
          neg1_nxt = 1'b0;
          if ((in_ch.value < modulus) && (in_ch.value != '0)) begin
            state_nxt = ST_ALIGN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_ALIGN: begin
        // Double the divisor while it still fits, one bit per cycle.
        if (alu_stat.dbl_fits) begin
          dr_nxt = {dr_r[WIDTH-2:0], 1'b0};
          du_nxt = {du_r[WIDTH-2:0], 1'b0};
          k_nxt  = k_r + KW'(1);
        end else begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        // One quotient bit per cycle, high bit first.
        if (k_r == '0) begin
          rem_nxt  = r1_r;
          acc_nxt  = u1_r;
          r1_nxt   = rem_step;
          u1_nxt   = acc_step;
          dr_nxt   = rem_step;
          du_nxt   = acc_step;
          neg0_nxt = neg1_r;
          neg1_nxt = !neg1_r;
          if (rem_step == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_ALIGN;
          end
        end else begin
          rem_nxt = rem_step;
          acc_nxt = acc_step;
          dr_nxt  = {1'b0, dr_r[WIDTH-1:1]};
          du_nxt  = {1'b0, du_r[WIDTH-1:1]};
          k_nxt   = k_r - KW'(1);
        end
      end
      ST_FIN: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_inverse_nxt = gcd_one ? inv_sel : '0;
          out_exists_nxt  = gcd_one;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    acc_r         <= acc_nxt;
    r1_r          <= r1_nxt;
    u1_r          <= u1_nxt;
    dr_r          <= dr_nxt;
    du_r          <= du_nxt;
    k_r           <= k_nxt;
    neg0_r        <= neg0_nxt;
    neg1_r        <= neg1_nxt;
    out_inverse_r <= out_inverse_nxt;
    out_exists_r  <= out_exists_nxt;
  end

  // In the align state the aligned divisor never exceeds the running remainder.
  a_align_fit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ALIGN |-> dr_r <= rem_r)
    else $error("aligned divisor exceeds remainder");

  // The quotient bit counter steps down by one in each subtract cycle with a nonzero count.
  a_sub_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUB) && (k_r != '0) |=> k_r == $past(k_r) - KW'(1))
    else $error("quotient bit counter skipped");

  // A new result only appears out of the finish state.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish state");

  // A valid inverse always lies below the modulus.
  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exists_r |-> out_inverse_r < modulus)
    else $error("inverse not reduced below modulus");

endmodule

// ===== sv/modular_inverse_core.sv =====
// Modular inverse core: each value beat yields one beat with the inverse of the
// value modulo the programmed modulus (0 to modulus-1) and an exists flag, which
// is clear and the inverse 0 when the value is not below the modulus or shares a
// factor with it. The extended Euclidean algorithm runs on a single
// shift-subtract unit: each Euclid step aligns the divisor (k doublings and one
// check that finds the next doubling no longer fits) and then subtracts one
// quotient bit at a time from bit k down, where k is the bit position of that
// step's quotient; one item occupies the block through all of its Euclid steps.
// The input is ready only while no item is in progress; a finished beat waits
// in the output register and does not hold off the next input. The modulus
// register sits at APB offset 0, resets to 0 and should only be written while
// the core is idle.
module modular_inverse_core import mi_pkg::*; #(
  parameter int WIDTH = MI_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  mi_in_if.sink                                in_ch,
  mi_out_if.source                             out_ch,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [((WIDTH > 32) ? 4 : 3)-1:0]    cfg_paddr,
  input  logic [((WIDTH > 32) ? 64 : 32)-1:0]  cfg_pwdata,
  output logic [((WIDTH > 32) ? 64 : 32)-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int CFG_DW  = (WIDTH > 32) ? 64 : 32;
  localparam int CFG_AW  = (WIDTH > 32) ? 4 : 3;
  localparam int CFG_LSB = (WIDTH > 32) ? 3 : 2;

  logic [WIDTH-1:0]        modulus_r, modulus_nxt;
  logic [CFG_AW-CFG_LSB-1:0] cfg_index;
  logic                    cfg_wr;

  // APB register decode; accesses complete without wait states.
  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[CFG_AW-1:CFG_LSB];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    modulus_nxt = modulus_r;
    if (cfg_wr && (cfg_index == (CFG_AW-CFG_LSB)'(MI_REG_MODULUS))) begin
      modulus_nxt = cfg_pwdata[WIDTH-1:0];
    end
  end

  // Read data for the modulus register, zero elsewhere.
  always_comb begin
    cfg_prdata = '0;
    if (cfg_index == (CFG_AW-CFG_LSB)'(MI_REG_MODULUS)) begin
      cfg_prdata = CFG_DW'(modulus_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= '0;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  // Euclidean engine with its sequencer and shared shift-subtract unit.
  mi_engine #(
    .WIDTH(WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .modulus (modulus_r)
  );

endmodule

// ===== test/tb_modular_inverse_core.sv =====
// Self-checking testbench for modular_inverse_core: APB modulus writes, value beats, scoreboard.
class inverse_scoreboard;
  localparam int W = mi_pkg::MI_WIDTH_DEF;

  typedef struct packed {
    logic [W-1:0] inverse;
    logic         exists;
  } inverse_beat_t;

  inverse_beat_t pending_inverses[$];
  logic [W-1:0]  modulus;
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   inverses_found;

  function new();
    modulus        = '0;
    mismatches     = 0;
    results_seen   = 0;
    inverses_found = 0;
  endfunction

  function void set_modulus(input logic [W-1:0] m);
    modulus = m;
  endfunction

  // Extended Euclid on magnitudes, with the sign of each coefficient tracked apart.
  function inverse_beat_t solve_inverse(input logic [W-1:0] a, input logic [W-1:0] m);
    inverse_beat_t beat;
    bit [63:0] r0, r1, r2, u0, u1, u2, q, inv;
    bit neg0, neg1;
    beat = '0;
    if (!(a < m)) return beat;
    r0 = 64'(m);
    r1 = 64'(a);
    u0 = 0;
    u1 = 1;
    neg0 = 1'b0;
    neg1 = 1'b0;
    for (int i = 0; i < 2 * W + 4 && r1 != 0; i++) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      u2 = u0 + q * u1;
      r0 = r1;
      r1 = r2;
      u0 = u1;
      neg0 = neg1;
      u1 = u2;
      neg1 = !neg0;
    end
    if (r0 != 1) return beat;
    if (u0 == 0) inv = 0;
    else if (neg0) inv = 64'(m) - (u0 % 64'(m));
    else inv = u0 % 64'(m);
    if (inv >= 64'(m)) inv = 0;
    beat.inverse = inv[W-1:0];
    beat.exists  = 1'b1;
    return beat;
  endfunction

  // An input beat was taken: queue what the core must answer.
  function void note_value(input logic [W-1:0] value);
    pending_inverses.push_back(solve_inverse(value, modulus));
  endfunction

  // An output beat was taken: compare it with the oldest expectation.
  function void check_result(input logic [W-1:0] inverse, input logic exists,
                             input longint unsigned stamp);
    inverse_beat_t want;
    results_seen++;
    if (pending_inverses.size() == 0) begin
      $display("%0d: unexpected result beat: inverse %h exists %0b", stamp, inverse, exists);
      mismatches++;
      return;
    end
    want = pending_inverses.pop_front();
    if (exists) inverses_found++;
    if (inverse !== want.inverse) begin
      $display("%0d: inverse mismatch: expected %h, actual %h", stamp, want.inverse, inverse);
      mismatches++;
    end
    if (exists !== want.exists) begin
      $display("%0d: exists mismatch: expected %0b, actual %0b", stamp, want.exists, exists);
      mismatches++;
    end
  endfunction
endclass

module tb_modular_inverse_core;
  import mi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = MI_WIDTH_DEF;
  localparam int LATENCY = 4 * W;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 90;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mi_in_if  #(.WIDTH(W)) in_ch ();
  mi_out_if #(.WIDTH(W)) out_ch ();

  modular_inverse_core #(.WIDTH(W)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  inverse_scoreboard sb = new();

  longint unsigned cycle_count = 0;
  int unsigned     values_sent = 0;
  int unsigned     moduli_used = 0;
  bit              src_idle_on = 1'b1;
  bit              sink_idle_on = 1'b1;
  bit              hold_out_req = 1'b0;

  always #1 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[modular_inverse_core] ERROR");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap(input bit idle_on);
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Values mostly below the modulus, with edges and out-of-range ones mixed in.
  function automatic logic [W-1:0] pick_value(input logic [W-1:0] m);
    logic [W-1:0] v;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: v = (m != 0) ? W'($urandom_range(m - 1, 0)) : W'($urandom);
      6: v = W'($urandom);
      7: begin
        case ($urandom_range(2, 0))
          0: v = '0;
          1: v = W'(1);
          default: v = m - 1;
        endcase
      end
      8: v = m + W'($urandom_range(3, 0));
      default: v = W'($urandom_range(255, 0));
    endcase
    return v;
  endfunction

  // Result side: take beats, stall at random, and hold off long on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.inverse, out_ch.exists, $time);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_out_req) begin
        hold_out_req = 1'b0;
        stall_left = 500;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(sink_idle_on);
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  // APB write with setup and access phases; the model register changes only for the modulus index.
  task automatic write_reg(input int unsigned index, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(index * 4);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (index == MI_REG_MODULUS) begin
      sb.set_modulus(data[W-1:0]);
      moduli_used++;
    end
  endtask

  // Offer one value beat after an optional gap and wait until it is taken.
  task automatic send_value(input logic [W-1:0] v);
    int unsigned gap;
    gap = pick_gap(src_idle_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_value(v);
    values_sent++;
  endtask

  // Close a stream of beats and wait until every result has come back.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (sb.pending_inverses.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [W-1:0] m;
    rst_n       <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Modulus zero straight out of reset: nothing has an inverse.
    send_value('0);
    send_value('1);
    send_value(W'(5));
    drain();

    // Modulus one: zero is coprime with it and inverts to zero.
    write_reg(MI_REG_MODULUS, 32'd1);
    send_value('0);
    send_value(W'(1));
    send_value('1);
    drain();

    // A write to any other index must leave the modulus alone.
    write_reg(MI_REG_MODULUS + 1, 32'd7);
    send_value('0);
    drain();

    // Largest modulus, which has small factors.
    write_reg(MI_REG_MODULUS, 32'hFFFF_FFFF);
    send_value('0);
    send_value(W'(1));
    send_value(W'(2));
    send_value(W'(3));
    send_value(W'(32'hFFFF_FFFE));
    send_value('1);
    send_value(W'(32'h1234_5678));
    drain();

    // Largest 32-bit prime.
    write_reg(MI_REG_MODULUS, 32'hFFFF_FFFB);
    send_value(W'(1));
    send_value(W'(32'hFFFF_FFFA));
    send_value(W'(32'h8000_0000));
    send_value(W'(32'hAAAA_AAAA));
    send_value(W'(32'h5555_5555));
    drain();

    // Smallest modulus with a real choice.
    write_reg(MI_REG_MODULUS, 32'd2);
    send_value('0);
    send_value(W'(1));
    send_value(W'(2));
    drain();

    // Random phases, each under its own modulus.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: m = W'($urandom) | W'(1);
        1: m = W'(32'hFFFF_FFFB);
        2: m = W'($urandom_range(1000, 2));
        3: m = W'(1) << $urandom_range(31, 1);
        4: m = '1;
        5: m = W'($urandom);
        6: m = W'(32'h7FFF_FFFF);
        7: m = W'($urandom_range(20, 2));
        8: m = W'(32'h8000_0000);
        9: m = W'(1);
        10: m = '0;
        default: m = W'(32'hFFFF_FFFE);
      endcase
      write_reg(MI_REG_MODULUS, 32'(m));
      src_idle_on  = !(p == 3 || p == 8);
      sink_idle_on = !(p == 3 || p == 8);
      if (p == 5) hold_out_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_value(pick_value(m));
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    $display("Covered %0d values under %0d modulus settings; %0d results, %0d with an inverse.",
             values_sent, moduli_used, sb.results_seen, sb.inverses_found);
    if (sb.mismatches == 0 && sb.pending_inverses.size() == 0) begin
      $display("[modular_inverse_core] OK");
    end else begin
      $display("[modular_inverse_core] ERROR");
    end
    $finish;
  end
endmodule
